### src/tlu_pkg.sv
package tlu_pkg;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } tlu_state_t;

endpackage

### src/tlu_row_if.sv
interface tlu_row_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sub_entry;
  logic signed [DATA_WIDTH-1:0] diag_entry;
  logic signed [DATA_WIDTH-1:0] super_entry;
  logic                         first_row;
  logic                         last_row;

  modport source (
    output valid, sub_entry, diag_entry, super_entry, first_row, last_row,
    input  ready
  );
  modport sink (
    input  valid, sub_entry, diag_entry, super_entry, first_row, last_row,
    output ready
  );
endinterface

### src/tlu_res_if.sv
interface tlu_res_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] lower_factor;
  logic signed [DATA_WIDTH-1:0] upper_diag;
  logic signed [DATA_WIDTH-1:0] upper_super;
  logic                         zero_pivot;
  logic                         row_last;

  modport source (
    output valid, lower_factor, upper_diag, upper_super, zero_pivot, row_last,
    input  ready
  );
  modport sink (
    input  valid, lower_factor, upper_diag, upper_super, zero_pivot, row_last,
    output ready
  );
endinterface

### src/tridiagonal_lu_factor.sv
// Tridiagonal LU factorization, one matrix row per beat.
// in_ch carries a row: sub, diagonal and super entry (signed fixed point,
// DATA_WIDTH bits, FRAC_BITS fraction bits) with first_row / last_row flags.
// out_ch returns one beat per row: the L multiplier, the U diagonal
// (saturated), the U super entry, a zero pivot flag and a copy of last_row.
// A row with first_row set, or one whose previous pivot is zero, skips the
// divider and multiplier and goes straight to the output register. Any other
// row runs a radix-2 restoring divider over DATA_WIDTH + FRAC_BITS quotient
// bits, a fix-up step, a hand-over of the quotient, then a shift-add
// multiplier over DATA_WIDTH multiplier bits and a last step to form and
// load the result.
// Rows are handled one at a time; in_ch.ready is high while no row is in work,
// so the next row is taken at the earliest in the cycle after the result loads.
// The result sits in an output register, so the next row is taken while it
// waits; a stalled out_ch holds the finished row until the register frees.
// Synchronous reset clears the handshakes and zeroes the stored previous
// upper diagonal and upper super entry.
module tridiagonal_lu_factor #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tlu_row_if.sink     in_ch,
  tlu_res_if.source   out_ch
);
  import tlu_pkg::*;

  localparam int MCW = $clog2(DATA_WIDTH);
  localparam int PW  = 2 * DATA_WIDTH;

  tlu_state_t state_r, state_nxt;

  logic signed [DATA_WIDTH-1:0] pu_r, pu_nxt;
  logic signed [DATA_WIDTH-1:0] ps_r, ps_nxt;
  logic signed [DATA_WIDTH-1:0] diag_r, diag_nxt;
  logic signed [DATA_WIDTH-1:0] sup_r, sup_nxt;
  logic signed [DATA_WIDTH-1:0] l_r, l_nxt;
  logic                         last_r, last_nxt;
  logic                         zp_r, zp_nxt;
  logic                         byp_r, byp_nxt;
  logic [DATA_WIDTH-1:0]        ml_r, ml_nxt;
  logic [DATA_WIDTH-1:0]        ms_r, ms_nxt;
  logic [DATA_WIDTH-1:0]        hi_r, hi_nxt;
  logic [DATA_WIDTH-1:0]        lo_r, lo_nxt;
  logic                         pneg_r, pneg_nxt;
  logic [MCW-1:0]               cnt_r, cnt_nxt;

  logic                         ov_r, ov_nxt;
  logic signed [DATA_WIDTH-1:0] ol_r, ol_nxt;
  logic signed [DATA_WIDTH-1:0] ou_r, ou_nxt;
  logic signed [DATA_WIDTH-1:0] os_r, os_nxt;
  logic                         ozp_r, ozp_nxt;
  logic                         olast_r, olast_nxt;

  logic                         div_start;
  logic                         div_done;
  logic signed [DATA_WIDTH-1:0] div_quot;

  logic                         in_fire;
  logic [DATA_WIDTH:0]          psum;
  logic [PW-1:0]                prod_sh;
  logic [DATA_WIDTH:0]          pclip;
  logic signed [DATA_WIDTH+1:0] dext;
  logic signed [DATA_WIDTH+1:0] tsum;
  logic signed [DATA_WIDTH-1:0] usat;
  logic signed [DATA_WIDTH-1:0] u_row;
  logic                         out_free;

  tlu_sdiv #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (in_ch.sub_entry),
    .den   (pu_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && (state_r == S_IDLE);
  assign div_start   = in_fire && !in_ch.first_row && (pu_r != '0);

  // shift-add step: add the multiplicand when the low multiplier bit is set
  assign psum    = {1'b0, hi_r} + {1'b0, (ml_r[0] ? ms_r : {DATA_WIDTH{1'b0}})};
  assign prod_sh = {hi_r, lo_r} >> FRAC_BITS;
  assign pclip   = (|prod_sh[PW-1:DATA_WIDTH]) ? {1'b1, {DATA_WIDTH{1'b0}}}
                                               : {1'b0, prod_sh[DATA_WIDTH-1:0]};
  assign dext    = {{2{diag_r[DATA_WIDTH-1]}}, diag_r};
  assign tsum    = pneg_r ? (dext + $signed({1'b0, pclip})) : (dext - $signed({1'b0, pclip}));

  always_comb begin
    if (tsum[DATA_WIDTH+1:DATA_WIDTH-1] == 3'b000 || tsum[DATA_WIDTH+1:DATA_WIDTH-1] == 3'b111) begin
      usat = tsum[DATA_WIDTH-1:0];
    end else if (tsum[DATA_WIDTH+1]) begin
      usat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      usat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

  assign u_row    = byp_r ? diag_r : usat;
  assign out_free = !ov_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    pu_nxt    = pu_r;
    ps_nxt    = ps_r;
    diag_nxt  = diag_r;
    sup_nxt   = sup_r;
    l_nxt     = l_r;
    last_nxt  = last_r;
    zp_nxt    = zp_r;
    byp_nxt   = byp_r;
    ml_nxt    = ml_r;
    ms_nxt    = ms_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    pneg_nxt  = pneg_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ol_nxt    = ol_r;
    ou_nxt    = ou_r;
    os_nxt    = os_r;
    ozp_nxt   = ozp_r;
    olast_nxt = olast_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          diag_nxt = in_ch.diag_entry;
          sup_nxt  = in_ch.last_row ? '0 : in_ch.super_entry;
          last_nxt = in_ch.last_row;
          l_nxt    = '0;
          zp_nxt   = !in_ch.first_row && (pu_r == '0);
          if (div_start) begin
            byp_nxt   = 1'b0;
            state_nxt = S_DIV;
          end else begin
            byp_nxt   = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          l_nxt     = div_quot;
          ml_nxt    = div_quot[DATA_WIDTH-1] ? (~div_quot + 1'b1) : div_quot;
          ms_nxt    = ps_r[DATA_WIDTH-1] ? (~ps_r + 1'b1) : ps_r;
          pneg_nxt  = div_quot[DATA_WIDTH-1] ^ ps_r[DATA_WIDTH-1];
          hi_nxt    = '0;
          lo_nxt    = '0;
          cnt_nxt   = MCW'(DATA_WIDTH - 1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        hi_nxt  = psum[DATA_WIDTH:1];
        lo_nxt  = {psum[0], lo_r[DATA_WIDTH-1:1]};
        ml_nxt  = {1'b0, ml_r[DATA_WIDTH-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold the row until the output register frees
        if (out_free) begin
          ov_nxt    = 1'b1;
          ol_nxt    = l_r;
          ou_nxt    = u_row;
          os_nxt    = sup_r;
          ozp_nxt   = zp_r;
          olast_nxt = last_r;
          pu_nxt    = u_row;
          ps_nxt    = sup_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pu_r    <= '0;
      ps_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pu_r    <= pu_nxt;
      ps_r    <= ps_nxt;
      ov_r    <= ov_nxt;
    end
    diag_r  <= diag_nxt;
    sup_r   <= sup_nxt;
    l_r     <= l_nxt;
    last_r  <= last_nxt;
    zp_r    <= zp_nxt;
    byp_r   <= byp_nxt;
    ml_r    <= ml_nxt;
    ms_r    <= ms_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    pneg_r  <= pneg_nxt;
    cnt_r   <= cnt_nxt;
    ol_r    <= ol_nxt;
    ou_r    <= ou_nxt;
    os_r    <= os_nxt;
    ozp_r   <= ozp_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.lower_factor = ol_r;
  assign out_ch.upper_diag   = ou_r;
  assign out_ch.upper_super  = os_r;
  assign out_ch.zero_pivot   = ozp_r;
  assign out_ch.row_last     = olast_r;

endmodule

### src/tlu_sdiv.sv
module tlu_sdiv #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic signed [DATA_WIDTH-1:0] den,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quot
);
  localparam int NSTEP = DATA_WIDTH + FRAC_BITS;
  localparam int CW    = $clog2(NSTEP);

  logic                  busy_r, busy_nxt;
  logic                  fix_r, fix_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] num_r, num_nxt;
  logic [DATA_WIDTH-1:0] den_r, den_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] q_r, q_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  neg_r, neg_nxt;
  logic [DATA_WIDTH-1:0] quot_r, quot_nxt;

  logic [DATA_WIDTH:0]   rsh;
  logic [DATA_WIDTH+1:0] diff;
  logic                  qb;
  logic [DATA_WIDTH-1:0] lim;
  logic [DATA_WIDTH-1:0] qmag;

  assign rsh  = {rem_r, num_r[DATA_WIDTH-1]};
  assign diff = {1'b0, rsh} - {2'b00, den_r};
  assign qb   = ~diff[DATA_WIDTH+1];
  assign lim  = neg_r ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
  assign qmag = (ovf_r || (q_r > lim)) ? lim : q_r;

  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    neg_nxt  = neg_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NSTEP - 1);
      num_nxt  = num[DATA_WIDTH-1] ? (~num + 1'b1) : num;
      den_nxt  = den[DATA_WIDTH-1] ? (~den + 1'b1) : den;
      neg_nxt  = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      // one dividend bit per cycle, zeros once the magnitude has shifted out
      num_nxt = {num_r[DATA_WIDTH-2:0], 1'b0};
      rem_nxt = qb ? diff[DATA_WIDTH-1:0] : rsh[DATA_WIDTH-1:0];
      q_nxt   = {q_r[DATA_WIDTH-2:0], qb};
      ovf_nxt = ovf_r | q_r[DATA_WIDTH-1];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      quot_nxt = neg_r ? (~qmag + 1'b1) : qmag;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    ovf_r  <= ovf_nxt;
    neg_r  <= neg_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
